// ===== hdl/vrpa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the voxel ray-potential accumulator.
// Field widths, register indexes and the default store depth; no dependencies.
package vrpa_pkg;

  localparam int NUM_VOXELS_DEF = 65536;

  localparam int INDEX_W = 16;
  localparam int DIST_W  = 31;
  localparam int REG_W   = 31;
  localparam int SCORE_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 32;

  // Quotient bits of the slope division; the quotient never exceeds rho.
  localparam int DIV_STEPS = REG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THICKNESS = 2'd0,
    REG_RHO       = 2'd1,
    REG_ETA       = 2'd2,
    REG_DELTA     = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_INTEGRATE = 1'b0,
    OP_READ      = 1'b1
  } op_t;

endpackage

// ===== hdl/voxel_ray_potential_accumulator_top.sv =====
`timescale 1ns / 1ps
// Voxel ray-potential accumulator: score store, potential evaluation, saturating update.
// Depends on vrpa_pkg.
//
// Scores sit in one single-port synchronous memory of NUM_VOXELS 32-bit words. After reset
// the block sweeps the memory to zero, one entry a cycle, and takes no word meanwhile;
// configuration writes are taken at any time. One item is handled at a time: a read, an
// out-of-range index, a zero difference or a sample outside the linear zone passes S_ABS,
// S_CLASS and S_ADD before the next acceptance; one inside it also passes S_DLOAD and
// S_DIV, the bit-serial divider forming rho*|diff|/thickness one quotient bit per cycle.
// The result waits in an output register, so the next word is taken while it is still
// unclaimed; the update stalls only if the previous result has not yet been taken.
module voxel_ray_potential_accumulator_top #(
  parameter int NUM_VOXELS = vrpa_pkg::NUM_VOXELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [vrpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vrpa_pkg::REG_W-1:0]       cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [15:0] voxel_index, [46:16] voxel_distance, [77:47] map_depth, [79:78] zero
  input  logic [vrpa_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [0] op
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [31:0] score
  output logic [vrpa_pkg::OUT_TDATA_W-1:0] m_tdata,
  // [0] saturated
  output logic                             m_tuser
);

  localparam int AW = (NUM_VOXELS > 1) ? $clog2(NUM_VOXELS) : 1;
  localparam int RW = vrpa_pkg::REG_W;
  localparam int SW = vrpa_pkg::SCORE_W;
  localparam int CW = $clog2(vrpa_pkg::DIV_STEPS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ABS, S_CLASS, S_DLOAD, S_DIV, S_ADD
  } state_t;

  state_t state;

  logic [RW-1:0] thickness, rho, eta, delta;

  logic [SW-1:0] mem [NUM_VOXELS];
  logic [SW-1:0] rd_data;
  logic [AW-1:0] clr_addr;

  logic [AW-1:0] addr_q;
  logic          is_read;
  logic          in_range;
  logic [RW:0]   diff;
  logic [RW-1:0] mag_a;
  logic          diff_pos;
  logic [RW-1:0] shift_mag;
  logic          shift_neg;
  logic [2*RW-1:0] prod;
  logic [RW-1:0] rem;
  logic [RW-1:0] dvd;
  logic [RW-1:0] quot;
  logic [CW-1:0] div_cnt;

  logic          out_valid;

  logic          accept;
  logic          out_free;
  logic          upd_fire;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [SW-1:0] mem_wdata;
  logic [AW-1:0] s_addr;
  logic          s_in_range;
  logic [RW:0]   trial;
  logic [SW-1:0] cur;
  logic [SW+1:0] sum;
  logic          sat;
  logic [SW-1:0] sum_sat;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign upd_fire = (state == S_ADD) && out_free;
  assign m_tvalid = out_valid;

  assign s_addr     = AW'(s_tdata[15:0]);
  assign s_in_range = {16'b0, s_tdata[15:0]} < 32'(NUM_VOXELS);

  assign trial = {rem, dvd[RW-1]} - {1'b0, thickness};

  always_comb begin
    cur = in_range ? rd_data : '0;
    if (shift_neg) begin
      sum = {{2{cur[SW-1]}}, cur} - {3'b0, shift_mag};
    end else begin
      sum = {{2{cur[SW-1]}}, cur} + {3'b0, shift_mag};
    end
    sat = !((sum[SW+1:SW-1] == 3'b000) || (sum[SW+1:SW-1] == 3'b111));
    if (!sat) begin
      sum_sat = sum[SW-1:0];
    end else if (sum[SW+1]) begin
      sum_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SW-1){1'b1}}};
    end
  end

  assign mem_we    = (state == S_CLEAR) || (upd_fire && !is_read && in_range);
  assign mem_addr  = (state == S_CLEAR) ? clr_addr : addr_q;
  assign mem_wdata = (state == S_CLEAR) ? '0 : sum_sat;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (accept) begin
      rd_data <= mem[s_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thickness <= '0;
      rho       <= '0;
      eta       <= '0;
      delta     <= '0;
    end else if (cfg_we) begin
      unique case (vrpa_pkg::cfg_reg_t'(cfg_index))
        vrpa_pkg::REG_THICKNESS: thickness <= cfg_data;
        vrpa_pkg::REG_RHO:       rho       <= cfg_data;
        vrpa_pkg::REG_ETA:       eta       <= cfg_data;
        vrpa_pkg::REG_DELTA:     delta     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (upd_fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NUM_VOXELS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            is_read  <= (vrpa_pkg::op_t'(s_tuser) == vrpa_pkg::OP_READ);
            addr_q   <= s_addr;
            in_range <= s_in_range;
            diff     <= {1'b0, s_tdata[46:16]} - {1'b0, s_tdata[77:47]};
            state    <= S_ABS;
          end
        end
        S_ABS: begin
          mag_a    <= diff[RW] ? RW'(-diff) : diff[RW-1:0];
          diff_pos <= !diff[RW] && (diff != '0);
          state    <= S_CLASS;
        end
        S_CLASS: begin
          shift_neg <= !diff_pos;
          prod      <= rho * mag_a;
          state     <= S_ADD;
          if (is_read || !in_range || (mag_a == '0)) begin
            shift_mag <= '0;
          end else if (mag_a > delta) begin
            shift_mag <= diff_pos ? '0 : eta;
          end else if (mag_a > thickness) begin
            shift_mag <= rho;
          end else begin
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          rem     <= prod[2*RW-1:RW];
          dvd     <= prod[RW-1:0];
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (!trial[RW]) begin
            rem <= trial[RW-1:0];
          end else begin
            rem <= {rem[RW-2:0], dvd[RW-1]};
          end
          dvd     <= {dvd[RW-2:0], 1'b0};
          quot    <= {quot[RW-2:0], !trial[RW]};
          div_cnt <= div_cnt + CW'(1);
          if (div_cnt == CW'(vrpa_pkg::DIV_STEPS - 1)) begin
            shift_mag <= {quot[RW-2:0], !trial[RW]};
            state     <= S_ADD;
          end
        end
        S_ADD: begin
          if (out_free) begin
            m_tdata <= sum_sat;
            m_tuser <= sat;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for voxel_ray_potential_accumulator_top: directed and random
// integrate/read words across several register settings, scored against a local predictor.
// Depends on vrpa_pkg and the accumulator RTL.
module tb_top;

  localparam int NUM_VOX = vrpa_pkg::NUM_VOXELS_DEF;
  localparam int unsigned ONE = 32'h10000;
  localparam int unsigned MAXV = 32'h7FFFFFFF;
  localparam int LIMIT = 1500000;
  localparam int SETTLE = 40;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_WORDS = 194;

  typedef struct packed {
    logic [31:0] score;
    logic        sat;
  } outcome_t;

  class score_book;
    logic [30:0]        thick, rho, eta, delta;
    logic signed [31:0] scores [NUM_VOX];
    outcome_t           pending [$];
    int                 mismatches;
    int                 checked;

    function new();
      thick = '0;
      rho = '0;
      eta = '0;
      delta = '0;
      foreach (scores[i]) scores[i] = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_reg(vrpa_pkg::cfg_reg_t r, logic [30:0] v);
      case (r)
        vrpa_pkg::REG_THICKNESS: thick = v;
        vrpa_pkg::REG_RHO:       rho = v;
        vrpa_pkg::REG_ETA:       eta = v;
        vrpa_pkg::REG_DELTA:     delta = v;
        default: ;
      endcase
    endfunction

    function longint ray_shift(logic [30:0] vox_dist, logic [30:0] depth);
      longint diff;
      longint unsigned a, mag;
      diff = longint'(vox_dist) - longint'(depth);
      a = (diff < 0) ? longint'(-diff) : longint'(diff);
      if (a > delta) return (diff > 0) ? 0 : -longint'(eta);
      if (a > thick) return (diff > 0) ? longint'(rho) : -longint'(rho);
      if (thick == 0 || a == 0) return 0;
      mag = (longint'(rho) * a) / longint'(thick);
      return (diff > 0) ? longint'(mag) : -longint'(mag);
    endfunction

    function void take_sample(vrpa_pkg::op_t op, logic [15:0] idx, logic [30:0] vox_dist,
                              logic [30:0] depth);
      longint   sum;
      outcome_t o;
      o.sat = 1'b0;
      if (op == vrpa_pkg::OP_READ) begin
        o.score = scores[idx];
      end else begin
        sum = longint'(scores[idx]) + ray_shift(vox_dist, depth);
        if (sum > 64'sd2147483647) begin
          sum = 64'sd2147483647;
          o.sat = 1'b1;
        end else if (sum < -64'sd2147483648) begin
          sum = -64'sd2147483648;
          o.sat = 1'b1;
        end
        scores[idx] = sum[31:0];
        o.score = sum[31:0];
      end
      pending.insert(pending.size(), o);
    endfunction

    function void match_result(logic [31:0] score, logic sat);
      outcome_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, score %h saturated %b", $time, score, sat);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (score !== want.score) begin
        $display("%0t: score mismatch, expected %h got %h", $time, want.score, score);
        mismatches++;
      end
      if (sat !== want.sat) begin
        $display("%0t: saturated mismatch, expected %b got %b", $time, want.sat, sat);
        mismatches++;
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [vrpa_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [vrpa_pkg::REG_W-1:0]       cfg_data = '0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [vrpa_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                             s_tuser = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [vrpa_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tuser;

  score_book book;
  bit        calm = 1'b0;
  int        cycles = 0;
  int        words_in = 0;
  int        settings = 1;

  voxel_ray_potential_accumulator_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.match_result(m_tdata, m_tuser);
  end

  // result side back-pressure: mostly short stalls, the odd long one
  initial begin : result_side
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (calm) begin
        m_tready = 1'b1;
      end else begin
        m_tready = ($urandom_range(0, 3) != 0);
        if (m_tready) hold = $urandom_range(0, 6);
        else if ($urandom_range(0, 9) == 0) hold = $urandom_range(15, 60);
        else hold = $urandom_range(0, 3);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 9);
    if (roll < 5) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned pick_reg();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return MAXV;
      2: return $urandom_range(1, 16);
      3: return $urandom_range(1, 8 * ONE);
      4: return $urandom() & MAXV;
      default: return $urandom_range(ONE / 16, 16 * ONE);
    endcase
  endfunction

  task automatic send_word(vrpa_pkg::op_t op, int unsigned idx, int unsigned vox_dist,
                           int unsigned depth);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {2'b00, depth[30:0], vox_dist[30:0], idx[15:0]};
    s_tuser = op;
    do @(posedge clk); while (!s_tready);
    book.take_sample(op, idx[15:0], vox_dist[30:0], depth[30:0]);
    words_in++;
  endtask

  // drop valid, let every result out, then allow the block to go quiet
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(vrpa_pkg::cfg_reg_t r, int unsigned v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = r;
    cfg_data = v[30:0];
    @(negedge clk);
    cfg_we = 1'b0;
    book.set_reg(r, v[30:0]);
  endtask

  task automatic set_all(int unsigned th, int unsigned rh, int unsigned et,
                         int unsigned de);
    write_reg(vrpa_pkg::REG_THICKNESS, th);
    write_reg(vrpa_pkg::REG_RHO, rh);
    write_reg(vrpa_pkg::REG_ETA, et);
    write_reg(vrpa_pkg::REG_DELTA, de);
    settings++;
  endtask

  // mostly samples near the surface so every zone is hit; the rest fully random
  task automatic send_random();
    vrpa_pkg::op_t op;
    int unsigned   idx, vox_dist, depth;
    longint        span, d;
    op = ($urandom_range(0, 4) == 0) ? vrpa_pkg::OP_READ : vrpa_pkg::OP_INTEGRATE;
    idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31) : ($urandom() & 32'hFFFF);
    depth = $urandom() & MAXV;
    if ($urandom_range(0, 9) < 6) begin
      span = ($urandom_range(0, 1) ? longint'(book.thick) : longint'(book.delta)) + 2;
      d = longint'(depth) + (longint'($urandom()) % (2 * span + 1)) - span;
      if (d < 0) d = 0;
      if (d > longint'(MAXV)) d = longint'(MAXV);
      vox_dist = d[31:0];
    end else begin
      vox_dist = $urandom() & MAXV;
    end
    send_word(op, idx, vox_dist, depth);
  endtask

  initial begin
    book = new();
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // reset registers: everything collapses to a zero shift
    send_word(vrpa_pkg::OP_INTEGRATE, 0, 0, 0);
    send_word(vrpa_pkg::OP_INTEGRATE, 16'hFFFF, MAXV, 0);
    send_word(vrpa_pkg::OP_INTEGRATE, 0, 0, MAXV);
    send_word(vrpa_pkg::OP_READ, 16'hFFFF, 0, 0);

    settle();
    set_all(2 * ONE, ONE, ONE / 2, 5 * ONE);
    send_word(vrpa_pkg::OP_INTEGRATE, 1, 3 * ONE, 2 * ONE);
    send_word(vrpa_pkg::OP_INTEGRATE, 1, 2 * ONE, 2 * ONE + ONE / 2);
    send_word(vrpa_pkg::OP_INTEGRATE, 1, 5 * ONE, 2 * ONE);
    send_word(vrpa_pkg::OP_INTEGRATE, 1, 2 * ONE, 5 * ONE);
    send_word(vrpa_pkg::OP_INTEGRATE, 1, 8 * ONE, 2 * ONE);
    send_word(vrpa_pkg::OP_INTEGRATE, 1, 2 * ONE, 8 * ONE);
    send_word(vrpa_pkg::OP_INTEGRATE, 1, 4 * ONE, 2 * ONE);
    send_word(vrpa_pkg::OP_INTEGRATE, 1, ONE, 6 * ONE);
    send_word(vrpa_pkg::OP_READ, 1, MAXV, MAXV);

    // zero thickness
    settle();
    set_all(0, ONE, ONE, MAXV);
    send_word(vrpa_pkg::OP_INTEGRATE, 2, 7 * ONE, 7 * ONE);
    send_word(vrpa_pkg::OP_INTEGRATE, 2, ONE + 1, ONE);

    // full-scale registers, clipping at both limits
    settle();
    set_all(MAXV, MAXV, MAXV, MAXV);
    send_word(vrpa_pkg::OP_INTEGRATE, 3, MAXV, 0);
    send_word(vrpa_pkg::OP_INTEGRATE, 3, MAXV, 0);
    send_word(vrpa_pkg::OP_INTEGRATE, 4, 0, MAXV);
    send_word(vrpa_pkg::OP_INTEGRATE, 4, 0, MAXV);
    send_word(vrpa_pkg::OP_READ, 4, 0, 0);

    settle();
    set_all(ONE, ONE, MAXV, 0);
    send_word(vrpa_pkg::OP_INTEGRATE, 5, 0, 1);
    send_word(vrpa_pkg::OP_INTEGRATE, 5, 0, 1);

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      set_all(pick_reg(), pick_reg(), pick_reg(), pick_reg());
      for (int n = 0; n < PHASE_WORDS; n++) send_random();
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("summary: %0d words in, %0d results scored, %0d register settings, %0d cycles",
             words_in, book.checked, settings, cycles);
    if (book.mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== voxel_ray_potential_accumulator_top.f =====
hdl/vrpa_pkg.sv
hdl/voxel_ray_potential_accumulator_top.sv
tb/sv/tb_top.sv
